### sv/rsbe_pkg.sv
// Shared types and constants of the rank/select bit vector engine.
// Depends on nothing; every other file imports it.
package rsbe_pkg;

  localparam int unsigned LINE_COUNT_DEF = 1024;

  localparam int FUNC_W   = 4;
  localparam int WIDX_W   = 12;
  localparam int WDATA_W  = 64;
  localparam int POS_W    = 19;
  localparam int VALUE_W  = 19;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 19;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // One directory entry: base count of ones before the line and three byte sub-counts.
  localparam int BASE_W = 19;
  localparam int SUB_W  = 24;
  localparam int DIR_W  = BASE_W + SUB_W;

  // Line numbers seen by the binary search never exceed 2048.
  localparam int LIDX_W = 12;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 4'd0,
    FN_FILL1 = 4'd1,
    FN_FILL0 = 4'd2,
    FN_BUILD = 4'd3,
    FN_SEL1  = 4'd4,
    FN_SEL0  = 4'd5,
    FN_RUN1F = 4'd6,
    FN_RUN0F = 4'd7,
    FN_RUN1R = 4'd8,
    FN_RUN0R = 4'd9
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANK    = 2'd1,
    ST_UNBUILT = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_SIZE0 = 1'b0,
    REG_SIZE1 = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_BLD_START,
    S_BLD_CNT,
    S_BLD_TOP,
    S_SRCH,
    S_SRCH_CMP,
    S_SEL_LINE,
    S_SEL_WORD,
    S_SEL_BIT,
    S_RUN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [SIZE_W-1:0] size0;
    logic [SIZE_W-1:0] size1;
    logic [1:0]        clr;
  } cfg_t;

endpackage

### sv/rsbe_if.sv
// Valid/ready channel interfaces for the request and result transfers.
// Depends on rsbe_pkg for the field widths.
interface rsbe_in_if import rsbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic                dim;
  logic [WIDX_W-1:0]   word_index;
  logic [WDATA_W-1:0]  word_data;
  logic [POS_W-1:0]    position;
  logic [POS_W-1:0]    range_end;

  modport source (output valid, func, dim, word_index, word_data, position, range_end,
                  input ready);
  modport sink   (input valid, func, dim, word_index, word_data, position, range_end,
                  output ready);
endinterface

interface rsbe_out_if import rsbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

### sv/rank_select_bitvector_engine.sv
// Top level of the rank/select bit vector engine: sequencer, word store and line directory.
// Depends on rsbe_pkg, rsbe_if (channel interfaces) and rsbe_regs (size registers).
//
//  channel  | direction | transfer when         | carries
//  in_i     | in        | valid & ready         | func, dim, word_index, word_data, position, range_end
//  out_o    | out       | valid & ready         | value, status
//  apb      | in        | psel&penable&pwrite   | size_dim0 at 0x0, size_dim1 at 0x4
//
// One request is worked at a time; every request returns one result transfer.
// A select takes at most ceil(log2(lines+2)) binary search steps.
// The result sits in an output register, so the next request is taken while it waits.
// Reset clears sizes, built flags and totals; the memories need no clearing pass.
module rank_select_bitvector_engine import rsbe_pkg::*; #(
  parameter int unsigned LINE_COUNT = LINE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rsbe_in_if.sink           in_i,
  rsbe_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CapBits = LINE_COUNT * 256;
  localparam int unsigned Words   = LINE_COUNT * 4;
  localparam int WAW = $clog2(Words);
  localparam int LNW = $clog2(LINE_COUNT + 1);
  localparam int WMA = WAW + 1;
  localparam int DMA = LNW + 1;

  cfg_t cfg;

  rsbe_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // ---------------------------------------------------------------- registers
  state_e state_q, state_d;

  logic [FUNC_W-1:0]  func_q;
  logic               dim_q;
  logic [WIDX_W-1:0]  widx_q;
  logic [WDATA_W-1:0] data_q;
  logic [POS_W-1:0]   pos_q, rend_q;

  logic [1:0]               built_q, built_d;
  logic [1:0][BASE_W-1:0]   ones_q, ones_d;
  logic [VALUE_W-1:0]       res_value_q, res_value_d;
  logic [STATUS_W-1:0]      res_status_q, res_status_d;

  logic [WAW-1:0] fidx_q, fidx_d, ffirst_q, ffirst_d, flast_q, flast_d;
  logic [5:0]     flo_q, flo_d;
  logic [6:0]     fhi_q, fhi_d;
  logic           fone_q, fone_d, bpad_q, bpad_d;

  logic [WAW-1:0]    bcnt_q, bcnt_d, blast_q, blast_d;
  logic [LNW-1:0]    lines_q, lines_d;
  logic [BASE_W-1:0] total_q, total_d;
  logic [8:0]        inc_q, inc_d;
  logic [SUB_W-1:0]  sub_q, sub_d;

  logic [LIDX_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, line_q, line_d;
  logic [1:0]        wsel_q, wsel_d;
  logic [19:0]       k_q, k_d;
  logic [7:0]        byte_q, byte_d;
  logic [2:0]        bidx_q, bidx_d, kb_q, kb_d;
  logic              none_q, none_d;

  logic [19:0] cur_q, cur_d;

  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [STATUS_W-1:0] out_status_q;

  // ---------------------------------------------------------------- memories
  logic [WDATA_W-1:0] word_mem_q [2**WMA];
  logic [DIR_W-1:0]   dir_mem_q  [2**DMA];
  logic [WDATA_W-1:0] word_rd_q;
  logic [DIR_W-1:0]   dir_rd_q;

  logic               wm_we, dm_we;
  logic [WMA-1:0]     wm_raddr, wm_waddr;
  logic [DMA-1:0]     dm_raddr, dm_waddr;
  logic [WDATA_W-1:0] wm_wdata;
  logic [DIR_W-1:0]   dm_wdata;

  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      word_mem_q[wm_waddr] <= wm_wdata;
    end
    word_rd_q <= word_mem_q[wm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dir_mem_q[dm_waddr] <= dm_wdata;
    end
    dir_rd_q <= dir_mem_q[dm_raddr];
  end

  // ---------------------------------------------------------------- helpers
  function automatic logic [6:0] pop64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  // Number of consecutive ones from bit 0 upward.
  function automatic logic [6:0] tones(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 63; i >= 0; i--) begin
      if (!v[i]) n = 7'(i);
    end
    return n;
  endfunction

  // Number of consecutive ones from bit 63 downward.
  function automatic logic [6:0] lones(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (!v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  function automatic logic [WMA-1:0] waddr(input logic d, input logic [19:0] idx);
    return {d, WAW'(idx)};
  endfunction

  // ---------------------------------------------------------------- request decode
  logic [POS_W-1:0]  eff0, eff1, sz, mx, tot, maxr;
  logic [19:0]       lines20, pad_end, fill_a, fill_b, fill_bm1;
  logic [LIDX_W-1:0] hi_init;
  logic              is_ones, is_fwd, load_bad, fill_bad, fill_empty, need_pad;
  logic              sel_bad, run_bad, rev_zero, out_free, run_stop;

  assign eff0 = (32'(cfg.size0) > CapBits) ? CapBits[POS_W-1:0] : cfg.size0;
  assign eff1 = (32'(cfg.size1) > CapBits) ? CapBits[POS_W-1:0] : cfg.size1;
  assign sz   = dim_q ? eff1 : eff0;
  assign mx   = (eff0 > eff1) ? eff0 : eff1;
  assign lines20 = (20'(mx) + 20'd255) >> 8;
  assign pad_end = lines20 << 8;
  assign need_pad = {1'b0, sz} < pad_end;
  assign hi_init  = LIDX_W'((20'(sz) + 20'd257) >> 8);

  assign is_ones = func_q == FN_SEL1 || func_q == FN_RUN1F || func_q == FN_RUN1R;
  assign is_fwd  = func_q == FN_RUN1F || func_q == FN_RUN0F;

  assign tot  = ones_q[dim_q];
  assign maxr = (func_q == FN_SEL1) ? tot : ((sz >= tot) ? sz - tot : '0);

  assign load_bad   = 32'(widx_q) >= Words;
  assign fill_bad   = pos_q > rend_q || 32'(rend_q) > CapBits;
  assign fill_empty = pos_q == rend_q;
  assign sel_bad    = !built_q[dim_q] || pos_q >= maxr;
  assign run_bad    = is_fwd ? pos_q >= sz : pos_q > sz;
  assign rev_zero   = !is_fwd && pos_q == '0;

  // The build pads with zeros from the used size up to the last line boundary.
  assign fill_a   = (func_q == FN_BUILD) ? 20'(sz) : 20'(pos_q);
  assign fill_b   = (func_q == FN_BUILD) ? pad_end : 20'(rend_q);
  assign fill_bm1 = fill_b - 20'd1;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = state_q == S_IDLE;

  // ---------------------------------------------------------------- datapath
  always_comb begin
    logic [WDATA_W-1:0] fmask, x, y;
    logic [6:0]  hi7, t7, n7, pc7, acc7;
    logic [5:0]  lo6, off6;
    logic [8:0]  inc_n;
    logic [SUB_W-1:0] sub_n;
    logic [12:0] sum13;
    logic [LIDX_W-1:0] ln12;
    logic [19:0] v20, base20, hit20, rem20, cur_n, cm1, lim20;
    logic [19:0] c20 [4];
    logic [1:0]  wv;
    logic        found;
    logic [2:0]  bsel, kbv, pbit, cnt;
    logic [3:0]  bc;

    fmask = '0; x = '0; y = '0;
    hi7 = '0; t7 = '0; n7 = '0; pc7 = '0; acc7 = '0;
    lo6 = '0; off6 = '0; inc_n = '0; sub_n = '0; sum13 = '0; ln12 = '0;
    v20 = '0; base20 = '0; hit20 = '0; rem20 = '0; cur_n = '0; cm1 = '0; lim20 = '0;
    for (int i = 0; i < 4; i++) c20[i] = '0;
    wv = '0; found = 1'b0; bsel = '0; kbv = '0; pbit = '0; cnt = '0; bc = '0;

    built_d = built_q & ~cfg.clr;
    ones_d = ones_q;
    res_value_d = res_value_q;
    res_status_d = res_status_q;
    fidx_d = fidx_q; ffirst_d = ffirst_q; flast_d = flast_q;
    flo_d = flo_q; fhi_d = fhi_q; fone_d = fone_q; bpad_d = bpad_q;
    bcnt_d = bcnt_q; blast_d = blast_q; lines_d = lines_q;
    total_d = total_q; inc_d = inc_q; sub_d = sub_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; line_d = line_q;
    wsel_d = wsel_q; k_d = k_q; byte_d = byte_q; bidx_d = bidx_q; kb_d = kb_q;
    none_d = none_q; cur_d = cur_q;
    run_stop = 1'b0;

    wm_we = 1'b0; wm_waddr = '0; wm_wdata = '0; wm_raddr = '0;
    dm_we = 1'b0; dm_waddr = '0; dm_wdata = '0; dm_raddr = '0;

    unique case (state_q)
      S_DECODE: begin
        res_value_d  = '0;
        res_status_d = ST_OK;
        lines_d = LNW'(lines20);
        blast_d = WAW'((lines20 << 2) - 20'd1);
        ffirst_d = WAW'(fill_a >> 6);
        flast_d  = WAW'(fill_bm1 >> 6);
        fidx_d   = WAW'(fill_a >> 6);
        flo_d    = fill_a[5:0];
        fhi_d    = 7'(fill_bm1[5:0]) + 7'd1;
        fone_d   = func_q == FN_FILL1;
        bpad_d   = func_q == FN_BUILD;
        wm_raddr = waddr(dim_q, fill_a >> 6);
        unique case (func_q)
          FN_LOAD: begin
            if (load_bad) begin
              res_status_d = ST_RANGE;
            end else begin
              wm_we = 1'b1;
              wm_waddr = waddr(dim_q, 20'(widx_q));
              wm_wdata = data_q;
              built_d[dim_q] = 1'b0;
            end
          end
          FN_FILL1, FN_FILL0: begin
            if (fill_bad) begin
              res_status_d = ST_RANGE;
            end else begin
              built_d[dim_q] = 1'b0;
            end
          end
          FN_SEL1, FN_SEL0: begin
            lo_d = '0;
            hi_d = hi_init;
            if (!built_q[dim_q]) begin
              res_status_d = ST_UNBUILT;
            end else if (pos_q >= maxr) begin
              res_status_d = ST_RANK;
            end
          end
          FN_RUN1F, FN_RUN0F, FN_RUN1R, FN_RUN0R: begin
            cur_d = 20'(pos_q);
            wm_raddr = is_fwd ? waddr(dim_q, 20'(pos_q) >> 6)
                              : waddr(dim_q, (20'(pos_q) - 20'd1) >> 6);
            if (run_bad) begin
              res_status_d = ST_RANGE;
            end
          end
          default: res_value_d = '0;
        endcase
      end

      S_FILL: begin
        lo6 = (fidx_q == ffirst_q) ? flo_q : 6'd0;
        hi7 = (fidx_q == flast_q) ? fhi_q : 7'd64;
        fmask = (hi7 == 7'd64) ? '1 : ((64'd1 << hi7) - 64'd1);
        fmask = fmask & ~((64'd1 << lo6) - 64'd1);
        wm_we = 1'b1;
        wm_waddr = waddr(dim_q, 20'(fidx_q));
        wm_wdata = fone_q ? (word_rd_q | fmask) : (word_rd_q & ~fmask);
        fidx_d = fidx_q + WAW'(1);
        wm_raddr = waddr(dim_q, 20'(fidx_q) + 20'd1);
      end

      S_BLD_START: begin
        total_d = '0;
        inc_d = '0;
        sub_d = '0;
        bcnt_d = '0;
        wm_raddr = waddr(dim_q, 20'd0);
      end

      S_BLD_CNT: begin
        // Words arrive one a cycle; the sub-count of word w is the ones before it in the line.
        pc7 = pop64(word_rd_q);
        sub_n = sub_q;
        unique case (bcnt_q[1:0])
          2'd0: sub_n = sub_q;
          2'd1: sub_n[7:0] = inc_q[7:0];
          2'd2: sub_n[15:8] = inc_q[7:0];
          2'd3: sub_n[23:16] = inc_q[7:0];
          default: sub_n = sub_q;
        endcase
        inc_n = inc_q + 9'(pc7);
        if (bcnt_q[1:0] == 2'd3) begin
          dm_we = 1'b1;
          dm_waddr = {dim_q, LNW'(bcnt_q >> 2)};
          dm_wdata = {total_q, sub_n};
          total_d = total_q + BASE_W'(inc_n);
          inc_d = '0;
          sub_d = '0;
        end else begin
          inc_d = inc_n;
          sub_d = sub_n;
        end
        bcnt_d = bcnt_q + WAW'(1);
        wm_raddr = waddr(dim_q, 20'(bcnt_q) + 20'd1);
      end

      S_BLD_TOP: begin
        dm_we = 1'b1;
        dm_waddr = {dim_q, lines_q};
        dm_wdata = {total_q, {SUB_W{1'b0}}};
        ones_d[dim_q] = total_q;
        built_d[dim_q] = 1'b1;
        res_value_d = VALUE_W'(total_q);
      end

      S_SRCH: begin
        sum13 = 13'(lo_q) + 13'(hi_q);
        if (lo_q < hi_q) begin
          mid_d = sum13[12:1];
          dm_raddr = {dim_q, LNW'(sum13[12:1])};
        end else begin
          ln12 = (lo_q == '0) ? '0 : lo_q - LIDX_W'(1);
          if (32'(ln12) >= LINE_COUNT) ln12 = LIDX_W'(LINE_COUNT - 1);
          line_d = ln12;
          dm_raddr = {dim_q, LNW'(ln12)};
        end
      end

      S_SRCH_CMP: begin
        base20 = 20'(dir_rd_q[DIR_W-1:SUB_W]);
        v20 = is_ones ? base20 : ({mid_q, 8'd0} - base20);
        if (v20 <= 20'(pos_q)) begin
          lo_d = mid_q + LIDX_W'(1);
        end else begin
          hi_d = mid_q;
        end
      end

      S_SEL_LINE: begin
        base20 = 20'(dir_rd_q[DIR_W-1:SUB_W]);
        hit20 = is_ones ? base20 : ({line_q, 8'd0} - base20);
        rem20 = 20'(pos_q) - hit20;
        for (int k = 1; k < 4; k++) begin
          v20 = 20'(dir_rd_q[8*k-1 -: 8]);
          c20[k] = is_ones ? v20 : (20'(64 * k) - v20);
        end
        if (rem20 < c20[2]) begin
          wv = (rem20 < c20[1]) ? 2'd0 : 2'd1;
        end else begin
          wv = (rem20 < c20[3]) ? 2'd2 : 2'd3;
        end
        wsel_d = wv;
        k_d = rem20 - c20[wv];
        wm_raddr = waddr(dim_q, 20'({line_q, 2'b00}) + 20'(wv));
      end

      S_SEL_WORD: begin
        // Find the byte that holds the wanted bit from running byte counts.
        x = is_ones ? word_rd_q : ~word_rd_q;
        acc7 = '0;
        for (int b = 0; b < 8; b++) begin
          bc = pop8(x[8*b +: 8]);
          if (!found && {1'b0, k_q[5:0]} < acc7 + 7'(bc)) begin
            found = 1'b1;
            bsel = 3'(b);
            kbv = 3'(k_q[5:0] - acc7[5:0]);
          end
          acc7 = acc7 + 7'(bc);
        end
        none_d = !found || (k_q[19:6] != '0);
        bidx_d = bsel;
        kb_d = kbv;
        byte_d = x[8*bsel +: 8];
      end

      S_SEL_BIT: begin
        for (int i = 0; i < 8; i++) begin
          if (byte_q[i]) begin
            if (!found && cnt == kb_q) begin
              found = 1'b1;
              pbit = 3'(i);
            end
            cnt = cnt + 3'd1;
          end
        end
        t7 = (none_q || !found) ? 7'd64 : {1'b0, bidx_q, pbit};
        res_value_d = VALUE_W'({line_q, 8'd0} + 20'({wsel_q, 6'd0}) + 20'(t7));
      end

      S_RUN: begin
        x = is_ones ? word_rd_q : ~word_rd_q;
        lim20 = 20'(sz);
        if (is_fwd) begin
          off6 = cur_q[5:0];
          y = x >> off6;
          t7 = tones(y);
          n7 = 7'd64 - 7'(off6);
          if (t7 < n7) begin
            cur_n = cur_q + 20'(t7);
            run_stop = 1'b1;
          end else begin
            cur_n = cur_q + 20'(n7);
            run_stop = !(cur_n < lim20);
          end
          res_value_d = VALUE_W'(((cur_n > lim20) ? lim20 : cur_n) - 20'(pos_q));
          wm_raddr = waddr(dim_q, cur_n >> 6);
        end else begin
          cm1 = cur_q - 20'd1;
          off6 = cm1[5:0];
          y = x << (6'd63 - off6);
          t7 = lones(y);
          n7 = 7'(off6) + 7'd1;
          if (t7 < n7) begin
            cur_n = cur_q - 20'(t7);
            run_stop = 1'b1;
          end else begin
            cur_n = cur_q - 20'(n7);
            run_stop = cur_n == '0;
          end
          res_value_d = VALUE_W'(20'(pos_q) - cur_n);
          wm_raddr = waddr(dim_q, (cur_n - 20'd1) >> 6);
        end
        cur_d = cur_n;
      end

      default: begin
        wm_raddr = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_DECODE;
      S_DECODE: begin
        unique case (func_q)
          FN_FILL1, FN_FILL0: state_d = (fill_bad || fill_empty) ? S_DONE : S_FILL;
          FN_BUILD:           state_d = need_pad ? S_FILL : S_BLD_START;
          FN_SEL1, FN_SEL0:   state_d = sel_bad ? S_DONE : S_SRCH;
          FN_RUN1F, FN_RUN0F, FN_RUN1R, FN_RUN0R:
                              state_d = (run_bad || rev_zero) ? S_DONE : S_RUN;
          default:            state_d = S_DONE;
        endcase
      end
      S_FILL: begin
        if (fidx_q == flast_q) state_d = bpad_q ? S_BLD_START : S_DONE;
      end
      S_BLD_START: state_d = (lines_q == '0) ? S_BLD_TOP : S_BLD_CNT;
      S_BLD_CNT:   if (bcnt_q == blast_q) state_d = S_BLD_TOP;
      S_BLD_TOP:   state_d = S_DONE;
      S_SRCH:      state_d = (lo_q < hi_q) ? S_SRCH_CMP : S_SEL_LINE;
      S_SRCH_CMP:  state_d = S_SRCH;
      S_SEL_LINE:  state_d = S_SEL_WORD;
      S_SEL_WORD:  state_d = S_SEL_BIT;
      S_SEL_BIT:   state_d = S_DONE;
      S_RUN:       if (run_stop) state_d = S_DONE;
      S_DONE:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      built_q <= '0;
      ones_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      ones_q  <= ones_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q <= in_i.func;
      dim_q  <= in_i.dim;
      widx_q <= in_i.word_index;
      data_q <= in_i.word_data;
      pos_q  <= in_i.position;
      rend_q <= in_i.range_end;
    end
    if (state_q == S_DONE && out_free) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
    end
    res_value_q <= res_value_d;  res_status_q <= res_status_d;
    fidx_q <= fidx_d;  ffirst_q <= ffirst_d;  flast_q <= flast_d;
    flo_q <= flo_d;  fhi_q <= fhi_d;  fone_q <= fone_d;  bpad_q <= bpad_d;
    bcnt_q <= bcnt_d;  blast_q <= blast_d;  lines_q <= lines_d;
    total_q <= total_d;  inc_q <= inc_d;  sub_q <= sub_d;
    lo_q <= lo_d;  hi_q <= hi_d;  mid_q <= mid_d;  line_q <= line_d;
    wsel_q <= wsel_d;  k_q <= k_d;  byte_q <= byte_d;  bidx_q <= bidx_d;
    kb_q <= kb_d;  none_q <= none_d;  cur_q <= cur_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

endmodule

### sv/rsbe_regs.sv
// Configuration register file behind the APB-style port: the two size registers.
// Depends on rsbe_pkg; a write also tells the engine to drop that dimension's directory.
module rsbe_regs import rsbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [SIZE_W-1:0] size0_q, size0_d, size1_q, size1_d;
  logic              wr;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    size0_d = size0_q;
    size1_d = size1_q;
    if (wr) begin
      unique case (idx)
        REG_SIZE0: size0_d = pwdata[SIZE_W-1:0];
        REG_SIZE1: size1_d = pwdata[SIZE_W-1:0];
        default:   size0_d = size0_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size0_q <= '0;
      size1_q <= '0;
    end else begin
      size0_q <= size0_d;
      size1_q <= size1_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIZE0: prdata = APB_DW'(size0_q);
      REG_SIZE1: prdata = APB_DW'(size1_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.size0 = size0_q;
  assign cfg_o.size1 = size1_q;
  assign cfg_o.clr   = {wr && idx == REG_SIZE1, wr && idx == REG_SIZE0};

endmodule

### verif/rank_select_bitvector_engine_tb.sv
// Self-checking testbench of the rank/select bit vector engine.
// Depends on rsbe_pkg, the channel interfaces in rsbe_if and the engine's top level.
`timescale 1ns / 1ps

module rank_select_bitvector_engine_tb;
  import rsbe_pkg::*;

  localparam int unsigned CAP   = LINE_COUNT_DEF * 256;
  localparam int unsigned WPD   = LINE_COUNT_DEF * 4;
  localparam int unsigned MASK  = 32'h7FFFF;
  localparam int unsigned WDOG  = 60000;
  localparam int unsigned HOLD  = 400;
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd10;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;

  typedef struct {
    logic [FUNC_W-1:0]  fn;
    logic               dm;
    logic [WIDX_W-1:0]  widx;
    logic [WDATA_W-1:0] data;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   rend;
  } req_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_e            st;
  } res_t;

  typedef struct {
    bit   typed;
    res_t res;
  } pend_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  rsbe_in_if  in_if ();
  rsbe_out_if out_if ();

  rank_select_bitvector_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if), .out_o(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the engine's state.
  logic [63:0] words_m [2][WPD];
  int unsigned base_m  [2][LINE_COUNT_DEF+1];
  int unsigned subc_m  [2][LINE_COUNT_DEF+1];
  bit          built_m [2];
  int unsigned ones_m  [2];
  int unsigned size_m  [2];

  res_t  result_q [$];
  pend_t pend_q [$];
  int    errors, n_items, n_results, idle_cycles;
  bit    hold_go;

  function automatic int unsigned eff_bits(int d);
    return (size_m[d] > CAP) ? CAP : size_m[d];
  endfunction

  function automatic void fill_bits(int d, int unsigned a, int unsigned b, bit one);
    int unsigned first, last, lo, hi;
    logic [63:0] m;
    first = a >> 6;
    last  = (b - 1) >> 6;
    for (int unsigned i = first; i <= last && i < WPD; i++) begin
      lo = (i == first) ? (a & 63) : 0;
      hi = (i == last) ? (((b - 1) & 63) + 1) : 64;
      m  = (hi == 64) ? '1 : ((64'd1 << hi) - 64'd1);
      m &= ~((64'd1 << lo) - 64'd1);
      if (one) words_m[d][i] |= m;
      else words_m[d][i] &= ~m;
    end
  endfunction

  function automatic int unsigned build_directory(int d);
    int unsigned mx, lines, sd, total, inc, sub;
    mx    = (eff_bits(0) > eff_bits(1)) ? eff_bits(0) : eff_bits(1);
    lines = (mx + 255) >> 8;
    sd    = eff_bits(d);
    total = 0;
    if (sd < lines * 256) fill_bits(d, sd, lines * 256, 1'b0);
    for (int unsigned i = 0; i < lines; i++) begin
      inc = 0;
      sub = 0;
      base_m[d][i] = total;
      for (int unsigned w = 0; w < 4; w++) begin
        if (w > 0) sub |= (inc & 255) << (8 * (w - 1));
        inc += $countones(words_m[d][i*4 + w]);
      end
      subc_m[d][i] = sub;
      total += inc;
    end
    base_m[d][lines] = total;
    subc_m[d][lines] = 0;
    ones_m[d]  = total & MASK;
    built_m[d] = 1'b1;
    return total & MASK;
  endfunction

  // Binary search over the line bases, then the k-th set bit of one word.
  function automatic int unsigned select_bit(int d, int unsigned r, bit ones);
    int unsigned lo, hi, mid, v, line, hit, rem, w, k, idx, sc;
    int unsigned c [4];
    logic [63:0] x;
    lo = 0;
    hi = (eff_bits(d) + 257) >> 8;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      v = ones ? base_m[d][mid] : mid * 256 - base_m[d][mid];
      if (v <= r) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) lo = 1;
    line = lo - 1;
    if (line >= LINE_COUNT_DEF) line = LINE_COUNT_DEF - 1;
    hit = ones ? base_m[d][line] : line * 256 - base_m[d][line];
    rem = r - hit;
    for (int unsigned j = 0; j < 4; j++) begin
      sc = (j == 0) ? 0 : ((subc_m[d][line] >> (8 * (j - 1))) & 255);
      c[j] = ones ? sc : 64 * j - sc;
    end
    if (rem < c[2]) w = (rem < c[1]) ? 0 : 1;
    else w = (rem < c[3]) ? 2 : 3;
    x = words_m[d][line*4 + w];
    if (!ones) x = ~x;
    k = rem - c[w];
    idx = 64;
    for (int i = 0; i < 64; i++) begin
      if (x[i] && idx == 64) begin
        if (k == 0) idx = i;
        else k--;
      end
    end
    return (line * 256 + 64 * w + idx) & MASK;
  endfunction

  function automatic int unsigned run_forward(int d, int unsigned p, int unsigned limit, bit ones);
    int unsigned cur, off, n, t;
    logic [63:0] w, sh;
    cur = p;
    while (cur < limit) begin
      w = words_m[d][(cur >> 6) % WPD];
      off = cur & 63;
      n = 64 - off;
      if (!ones) w = ~w;
      sh = ~(w >> off);
      t = 0;
      while (t < 64 && !sh[t]) t++;
      if (t < n) begin
        cur += t;
        break;
      end
      cur += n;
    end
    if (cur > limit) cur = limit;
    return cur - p;
  endfunction

  function automatic int unsigned run_reverse(int d, int unsigned e, bit ones);
    int unsigned cur, off, n, t;
    logic [63:0] w, sh;
    cur = e;
    while (cur > 0) begin
      w = words_m[d][((cur - 1) >> 6) % WPD];
      off = (cur - 1) & 63;
      n = off + 1;
      if (!ones) w = ~w;
      sh = ~(w << (63 - off));
      t = 0;
      while (t < 64 && !sh[63 - t]) t++;
      if (t < n) begin
        cur -= t;
        break;
      end
      cur -= n;
    end
    return e - cur;
  endfunction

  function automatic res_t engine_step(req_t r);
    res_t o;
    int d;
    int unsigned sz, maxr;
    d = r.dm;
    sz = eff_bits(d);
    o.value = '0;
    o.st = ST_OK;
    case (r.fn)
      FN_LOAD: begin
        words_m[d][r.widx] = r.data;
        built_m[d] = 1'b0;
      end
      FN_FILL1, FN_FILL0: begin
        if (r.pos > r.rend || r.rend > CAP) o.st = ST_RANGE;
        else begin
          if (r.pos < r.rend) fill_bits(d, r.pos, r.rend, r.fn == FN_FILL1);
          built_m[d] = 1'b0;
        end
      end
      FN_BUILD: o.value = build_directory(d);
      FN_SEL1, FN_SEL0: begin
        maxr = (r.fn == FN_SEL1) ? ones_m[d] : ((sz >= ones_m[d]) ? sz - ones_m[d] : 0);
        if (!built_m[d]) o.st = ST_UNBUILT;
        else if (r.pos >= maxr) o.st = ST_RANK;
        else o.value = select_bit(d, r.pos, r.fn == FN_SEL1);
      end
      FN_RUN1F, FN_RUN0F: begin
        if (r.pos >= sz) o.st = ST_RANGE;
        else o.value = run_forward(d, r.pos, sz, r.fn == FN_RUN1F);
      end
      FN_RUN1R, FN_RUN0R: begin
        if (r.pos > sz) o.st = ST_RANGE;
        else o.value = run_reverse(d, r.pos, r.fn == FN_RUN1R);
      end
      default: ;
    endcase
    return o;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result checking and prediction, both at the clock edge.
  always @(posedge clk_i) begin : monitor
    res_t  exp_r, pred_r;
    pend_t p;
    req_t  r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: value %0d status %0d",
                   $time, out_if.value, out_if.status);
        end else begin
          exp_r = result_q.pop_front();
          if (out_if.value !== exp_r.value) begin
            errors++;
            $display("%0t: value expected %0d actual %0d", $time, exp_r.value, out_if.value);
          end
          if (out_if.status !== exp_r.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, out_if.status);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        r.fn = in_if.func; r.dm = in_if.dim; r.widx = in_if.word_index;
        r.data = in_if.word_data; r.pos = in_if.position; r.rend = in_if.range_end;
        pred_r = engine_step(r);
        p = pend_q.pop_front();
        result_q.push_back(p.typed ? p.res : pred_r);
        n_items++;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, result_q.size());
        $display("rank_select_bitvector_engine regression: fail");
        $finish;
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold-off on request.
  initial begin : receiver
    int r;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        out_if.ready <= (r < 70);
        if (r < 70) repeat ($urandom_range(1, 30)) @(posedge clk_i);
        else if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clk_i);
        else repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end
    end
  end

  task automatic send_req(req_t r, bit typed, res_t er);
    pend_t p;
    p.typed = typed;
    p.res = er;
    pend_q.push_back(p);
    in_if.valid <= 1'b1;
    in_if.func <= r.fn; in_if.dim <= r.dm; in_if.word_index <= r.widx;
    in_if.word_data <= r.data; in_if.position <= r.pos; in_if.range_end <= r.rend;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic sender_gap(bit no_gap);
    int r, n;
    r = $urandom_range(0, 99);
    n = (no_gap || r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (result_q.size() != 0 || pend_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(reg_idx_e idx, logic [SIZE_W-1:0] val);
    logic [31:0] junk;
    junk = $urandom();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {junk[31:SIZE_W], val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    size_m[idx] = val;
    built_m[idx] = 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic res_t mk_res(int unsigned v, status_e st);
    res_t o;
    o.value = v;
    o.st = st;
    return o;
  endfunction

  function automatic req_t mk_req(logic [FUNC_W-1:0] fn, logic dm, logic [WIDX_W-1:0] widx,
                                  logic [WDATA_W-1:0] data, logic [POS_W-1:0] pos,
                                  logic [POS_W-1:0] rend);
    req_t r;
    r.fn = fn; r.dm = dm; r.widx = widx; r.data = data; r.pos = pos; r.rend = rend;
    return r;
  endfunction

  // Mostly well-formed traffic for the current sizes, with some noise.
  function automatic req_t random_req();
    req_t r;
    int d, cls;
    int unsigned sz, a, b, mx, maxr;
    logic [WDATA_W-1:0] data;
    d = $urandom_range(0, 1);
    sz = eff_bits(d);
    cls = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: data = '1;
      1: data = '0;
      2: data = {$urandom(), $urandom()};
      default: data = {$urandom(), $urandom()} & {$urandom(), $urandom()};
    endcase
    r = mk_req(FN_LOAD, d, '0, data, '0, '0);
    if (cls < 12) begin
      mx = (sz + 63) / 64;
      mx = (mx == 0) ? 16 : (mx > WPD) ? WPD : mx;
      r.widx = $urandom_range(0, mx - 1);
    end else if (cls < 25) begin
      r.fn = $urandom_range(0, 1) ? FN_FILL1 : FN_FILL0;
      a = $urandom_range(0, sz);
      b = a + $urandom_range(0, 300);
      r.pos = a;
      r.rend = (b > sz) ? sz : b;
    end else if (cls < 40) begin
      r.fn = FN_BUILD;
    end else if (cls < 70) begin
      r.fn = $urandom_range(0, 1) ? FN_SEL1 : FN_SEL0;
      maxr = (r.fn == FN_SEL1) ? ones_m[d] : ((sz >= ones_m[d]) ? sz - ones_m[d] : 0);
      r.pos = ($urandom_range(0, 9) == 0 || maxr == 0) ? maxr : $urandom_range(0, maxr - 1);
    end else if (cls < 93) begin
      case ($urandom_range(0, 3))
        0: r.fn = FN_RUN1F;
        1: r.fn = FN_RUN0F;
        2: r.fn = FN_RUN1R;
        default: r.fn = FN_RUN0R;
      endcase
      r.pos = ($urandom_range(0, 9) == 0) ? sz : $urandom_range(0, sz);
    end else begin
      r.fn = ($urandom_range(0, 1)) ? $urandom_range(FN_SPARE_LO, FN_SPARE_HI) : $urandom();
      r.widx = $urandom();
      r.data = {$urandom(), $urandom()};
      r.pos = $urandom();
      r.rend = $urandom();
    end
    return r;
  endfunction

  initial begin : stimulus
    req_t  dir_req [$];
    pend_t dir_exp [$];
    pend_t pe;
    res_t  none;
    int unsigned s0, s1, n_phase_items;
    none = mk_res(0, ST_OK);
    errors = 0; n_items = 0; n_results = 0; idle_cycles = 0; hold_go = 1'b0;
    rst_ni = 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_if.valid <= 1'b0; in_if.func <= '0; in_if.dim <= 1'b0; in_if.word_index <= '0;
    in_if.word_data <= '0; in_if.position <= '0; in_if.range_end <= '0;
    for (int d = 0; d < 2; d++) begin
      built_m[d] = 0; ones_m[d] = 0; size_m[d] = 0;
      for (int i = 0; i <= LINE_COUNT_DEF; i++) begin
        base_m[d][i] = 0; subc_m[d][i] = 0;
      end
      for (int i = 0; i < WPD; i++) words_m[d][i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, both sizes zero. Every word is filled early so no later read
    // touches an unwritten word.
    pe.typed = 1;
    dir_req.push_back(mk_req(FN_SEL1, 0, 0, 0, 0, 0));           pe.res = mk_res(0, ST_UNBUILT); dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_SEL0, 1, 0, 0, CAP, 0));         pe.res = mk_res(0, ST_UNBUILT); dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_RUN1F, 0, 0, 0, 0, 0));          pe.res = mk_res(0, ST_RANGE);   dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_RUN0R, 1, 0, 0, 1, 0));          pe.res = mk_res(0, ST_RANGE);   dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_RUN1R, 0, 0, 0, 0, 0));          pe.res = none;                  dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_FILL0, 0, 0, 0, 0, CAP));        pe.res = none;                  dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_FILL0, 1, 0, 0, 0, CAP));        pe.res = none;                  dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_LOAD, 1, WPD - 1, '1, 0, 0));    pe.res = none;                  dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_LOAD, 0, 0, 64'h8000_0000_0000_0001, 0, 0)); pe.res = none;      dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_FILL1, 0, 0, 0, 10, 5));         pe.res = mk_res(0, ST_RANGE);   dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_FILL0, 1, 0, 0, 0, CAP + 1));    pe.res = mk_res(0, ST_RANGE);   dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_FILL1, 0, 0, 0, 7, 7));          pe.res = none;                  dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_SPARE_HI, 1, '1, '1, '1, '1));   pe.res = none;                  dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_BUILD, 0, 0, 0, 0, 0));          pe.res = none;                  dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_BUILD, 0, 0, 0, 0, 0));          pe.res = none;                  dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_SEL1, 0, 0, 0, 0, 0));           pe.res = mk_res(0, ST_RANK);    dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_SEL0, 0, 0, 0, 0, 0));           pe.res = mk_res(0, ST_RANK);    dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_RUN0F, 1, 0, 0, CAP, 0));        pe.res = mk_res(0, ST_RANGE);   dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_BUILD, 1, 0, 0, 0, 0));          pe.res = none;                  dir_exp.push_back(pe);
    pe.typed = 0;
    dir_req.push_back(mk_req(FN_LOAD, 0, 2048, 64'h0123_4567_89AB_CDEF, 0, 0)); dir_exp.push_back(pe);
    dir_req.push_back(mk_req(FN_RUN1R, 1, 0, 0, 0, 0));          dir_exp.push_back(pe);
    foreach (dir_req[i]) begin
      send_req(dir_req[i], dir_exp[i].typed, dir_exp[i].res);
      sender_gap(0);
    end
    drain();

    // Phases of random traffic, each under its own pair of sizes.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin s0 = CAP; s1 = CAP; end
        1: begin s0 = MASK; s1 = 1000; end
        2: begin s0 = 300; s1 = 64; end
        3: begin s0 = 0; s1 = 256; end
        4: begin s0 = 257; s1 = 1; end
        default: begin s0 = $urandom_range(0, 2048); s1 = $urandom_range(0, 2048); end
      endcase
      write_size(REG_SIZE0, s0);
      write_size(REG_SIZE1, s1);
      n_phase_items = (ph < 2) ? 40 : 115;
      if (ph == 2) hold_go = 1'b1;
      for (int k = 0; k < n_phase_items; k++) begin
        send_req(random_req(), 0, none);
        sender_gap(ph == 2 && k < 40);
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("Covered %0d requests and %0d results over 12 size settings, incl. clamped sizes,",
             n_items, n_results);
    $display("error statuses, rebuilds and a long result hold-off; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("rank_select_bitvector_engine regression: pass");
    end else begin
      $display("rank_select_bitvector_engine regression: fail");
    end
    $finish;
  end

endmodule
